// File: hdl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the sorted identifier table
// Holds the status codes, the controller states and the control word that
// the controller broadcasts to every table cell.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

    // Default number of cells in the table.
    localparam int CAPACITY_DEF = 16;

    // Widths of the word fields.
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_DUPLICATE = 2'd1,
        STATUS_ABSENT    = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_APPLY
    } state_t;

    // Control word broadcast to all cells.
    typedef struct packed {
        logic            compare;   // latch compare flags against pid
        logic            shift_in;  // commit an insert
        logic            shift_out; // commit a remove
        logic [ID_W-1:0] pid;       // identifier under work
    } cell_ctrl_t;

endpackage : sit_pkg

`default_nettype wire

// File: hdl/sorted_id_table.sv
// ----------------------------------------------------------------------------
// sorted_id_table: ascending set of process identifiers in a row of cells
// Inserts or removes one identifier per command and reports a status and the
// entry count after the operation.
//
//   Channel  Handshake        Fields
//   -------  ---------------  --------------------------
//   command  start / busy     opcode, process_id
//   result   done (strobe)    status, entry_count
//
// A command is taken when start is high and busy is low. It passes through
// the compare step, where every cell latches its flags, and then the apply
// step, where every cell shifts at once; the result word shows in the cycle
// after the apply step for exactly one cycle. A new command can be taken in
// the cycle the result shows; busy holds off a new command until then.
// Reset empties the table at once; there is no clearing pass. The result
// cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_id_table #(
    parameter int CAPACITY = sit_pkg::CAPACITY_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         opcode,
    input  wire logic [sit_pkg::ID_W-1:0]     process_id,
    output logic                              done,
    output logic [sit_pkg::STATUS_W-1:0]      status,
    output logic [sit_pkg::COUNT_W-1:0]       entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    sit_pkg::state_t             state_reg;
    sit_pkg::state_t             state_next;
    logic                        op_reg;
    logic [sit_pkg::ID_W-1:0]    pid_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        done_reg;
    logic                        done_next;
    sit_pkg::status_t            status_reg;
    sit_pkg::status_t            status_next;
    logic [sit_pkg::COUNT_W-1:0] entry_count_reg;
    logic [sit_pkg::COUNT_W-1:0] entry_count_next;

    sit_pkg::cell_ctrl_t         ctrl;
    logic                        accept;
    logic                        found;
    logic                        full;
    logic                        ins_ok;
    logic                        rem_ok;

    logic [CAPACITY-1:0]         lt_vec;
    logic [CAPACITY-1:0]         eq_vec;
    logic [CAPACITY-1:0]         occ_vec;
    logic [sit_pkg::ID_W-1:0]    id_vec [CAPACITY];

    assign accept = start && (state_reg == sit_pkg::ST_IDLE);
    assign found  = |eq_vec;
    assign full   = occ_vec[CAPACITY-1];
    assign ins_ok = (state_reg == sit_pkg::ST_APPLY) && (op_reg == sit_pkg::OP_INSERT)
                    && !found && !full;
    assign rem_ok = (state_reg == sit_pkg::ST_APPLY) && (op_reg == sit_pkg::OP_REMOVE)
                    && found;

    // Row of cells, each linked to its two neighbors.
    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                     left_lt;
            logic [sit_pkg::ID_W-1:0] left_id;
            logic                     left_occ;
            logic [sit_pkg::ID_W-1:0] right_id;
            logic                     right_occ;

            if (i == 0)
            begin : g_head
                assign left_lt  = 1'b0;
                assign left_id  = pid_reg;
                assign left_occ = 1'b0;
            end
            else
            begin : g_body
                assign left_lt  = lt_vec[i-1];
                assign left_id  = id_vec[i-1];
                assign left_occ = occ_vec[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_id  = pid_reg;
                assign right_occ = 1'b0;
            end
            else
            begin : g_inner
                assign right_id  = id_vec[i+1];
                assign right_occ = occ_vec[i+1];
            end

            sit_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .first     (i == 0),
                .left_lt   (left_lt),
                .left_id   (left_id),
                .left_occ  (left_occ),
                .right_id  (right_id),
                .right_occ (right_occ),
                .lt        (lt_vec[i]),
                .eq        (eq_vec[i]),
                .id        (id_vec[i]),
                .occ       (occ_vec[i])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sit_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sit_pkg::ST_COMPARE;
                end
            end
            sit_pkg::ST_COMPARE: state_next = sit_pkg::ST_APPLY;
            sit_pkg::ST_APPLY:   state_next = sit_pkg::ST_IDLE;
            default:             state_next = sit_pkg::ST_IDLE;
        endcase
    end

    // Controller outputs: cell control word and busy.
    always_comb
    begin
        ctrl.compare   = 1'b0;
        ctrl.shift_in  = 1'b0;
        ctrl.shift_out = 1'b0;
        ctrl.pid       = pid_reg;
        busy           = 1'b1;
        unique case (state_reg)
            sit_pkg::ST_IDLE:    busy = 1'b0;
            sit_pkg::ST_COMPARE: ctrl.compare = 1'b1;
            sit_pkg::ST_APPLY:
            begin
                ctrl.shift_in  = ins_ok;
                ctrl.shift_out = rem_ok;
            end
            default:             busy = 1'b1;
        endcase
    end

    // Status, count and result word.
    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        if (op_reg == sit_pkg::OP_INSERT)
        begin
            if (found)
            begin
                status_next = sit_pkg::STATUS_DUPLICATE;
            end
            else if (full)
            begin
                status_next = sit_pkg::STATUS_FULL;
            end
            else
            begin
                status_next = sit_pkg::STATUS_DONE;
            end
        end
        else
        begin
            status_next = found ? sit_pkg::STATUS_DONE : sit_pkg::STATUS_ABSENT;
        end

        done_next        = (state_reg == sit_pkg::ST_APPLY);
        entry_count_next = sit_pkg::COUNT_W'(count_next);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sit_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            pid_reg <= process_id;
        end
        if (done_next)
        begin
            status_reg      <= status_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

`ifndef SYNTHESIS
    // The count register tracks the number of occupied cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == 32'(count_reg))
        else $error("entry count disagrees with occupied cells");

    // Occupied cells always form a prefix starting at cell zero.
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec + CAPACITY'(1)) & occ_vec) == '0)
        else $error("occupied cells are not a prefix");

    // Every apply step is followed by exactly one result strobe.
    a_apply_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sit_pkg::ST_APPLY) |=> done)
        else $error("apply step gave no result");

    // A result strobe only follows an apply step.
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == sit_pkg::ST_APPLY))
        else $error("result strobe without apply step");
`endif

endmodule : sorted_id_table

`default_nettype wire

// File: hdl/sit_cell.sv
// ----------------------------------------------------------------------------
// sit_cell: one cell of the sorted identifier table
// Holds one identifier and its occupied bit, compares it with the broadcast
// identifier, and on a commit keeps its value or takes a neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sit_pkg::cell_ctrl_t      ctrl,
    input  wire logic                     first,     // this is cell zero
    input  wire logic                     left_lt,
    input  wire logic [sit_pkg::ID_W-1:0] left_id,
    input  wire logic                     left_occ,
    input  wire logic [sit_pkg::ID_W-1:0] right_id,
    input  wire logic                     right_occ,
    output logic                          lt,
    output logic                          eq,
    output logic [sit_pkg::ID_W-1:0]      id,
    output logic                          occ
);

    logic                     lt_reg;
    logic                     lt_next;
    logic                     eq_reg;
    logic                     eq_next;
    logic                     occ_reg;
    logic                     occ_next;
    logic [sit_pkg::ID_W-1:0] id_reg;
    logic [sit_pkg::ID_W-1:0] id_next;

    // Compare flags: only an occupied cell can be below or equal to pid.
    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctrl.compare)
        begin
            lt_next = occ_reg && (id_reg < ctrl.pid);
            eq_next = occ_reg && (id_reg == ctrl.pid);
        end
    end

    // Commit: cells below pid stay; the rest shift toward or away from zero.
    always_comb
    begin
        id_next  = id_reg;
        occ_next = occ_reg;
        if (ctrl.shift_in && !lt_reg)
        begin
            if (first || left_lt)
            begin
                id_next  = ctrl.pid;
                occ_next = 1'b1;
            end
            else
            begin
                id_next  = left_id;
                occ_next = left_occ;
            end
        end
        else if (ctrl.shift_out && !lt_reg)
        begin
            id_next  = right_id;
            occ_next = right_occ;
        end
    end

    // Control flags with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            occ_reg <= 1'b0;
        end
        else
        begin
            lt_reg  <= lt_next;
            eq_reg  <= eq_next;
            occ_reg <= occ_next;
        end
    end

    // Identifier storage needs no reset.
    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign lt  = lt_reg;
    assign eq  = eq_reg;
    assign id  = id_reg;
    assign occ = occ_reg;

endmodule : sit_cell

`default_nettype wire
